// ===== sv/olist_pkg.sv =====
package olist_pkg;

  localparam int DEPTH = 16;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int IDX_W = $clog2(DEPTH);
  localparam int CMD_W = 2;
  localparam int POS_W = 5;
  localparam int VAL_W = 32;
  localparam int ST_W  = 2;
  localparam int CMP_W = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

  localparam int IN_BITS  = CMD_W + POS_W + 2 * VAL_W;
  localparam int IN_W     = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_BITS = ST_W + 2 * POS_W;
  localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT = 2'd0,
    CMD_DELETE = 2'd1,
    CMD_SEARCH = 2'd2,
    CMD_AMEND  = 2'd3
  } cmd_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK        = 2'd0,
    ST_BAD_POS   = 2'd1,
    ST_FULL      = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } state_t;

  // controller to datapath commands
  typedef struct packed {
    logic load;  // capture the incoming transaction
    logic exec;  // run the held command and fill the result register
  } dp_ctrl_t;

endpackage

// ===== sv/olist_ctrl.sv =====
module olist_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  output logic                m_tvalid,
  input  logic                m_tready,
  output olist_pkg::dp_ctrl_t ctrl
);
  import olist_pkg::*;

  state_t state, state_next;
  logic   out_free;

  assign out_free = !m_tvalid || m_tready;

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (s_tvalid) state_next = S_EXEC;
      end
      S_EXEC: begin
        if (out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    s_tready  = 1'b0;
    ctrl.load = 1'b0;
    ctrl.exec = 1'b0;
    case (state)
      S_IDLE: begin
        s_tready  = 1'b1;
        ctrl.load = s_tvalid;
      end
      S_EXEC: begin
        ctrl.exec = out_free;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (ctrl.exec) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
    end
  end

  a_load_to_exec: assert property (@(posedge clk) disable iff (rst)
    ctrl.load |=> state == S_EXEC) else $error("load did not enter exec");
  a_exec_gives_result: assert property (@(posedge clk) disable iff (rst)
    ctrl.exec |=> m_tvalid) else $error("exec produced no result");
  a_one_cmd: assert property (@(posedge clk) disable iff (rst)
    $onehot0({ctrl.load, ctrl.exec})) else $error("load and exec together");
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |-> !ctrl.exec) else $error("result overwritten");

endmodule

// ===== sv/olist_dp.sv =====
module olist_dp (
  input  logic                        clk,
  input  logic                        rst,
  input  olist_pkg::dp_ctrl_t         ctrl,
  input  logic [olist_pkg::IN_W-1:0]  in_data,
  output logic [olist_pkg::OUT_W-1:0] out_data
);
  import olist_pkg::*;

  logic [CMD_W-1:0] cmd_r;
  logic [POS_W-1:0] pos_r;
  logic [VAL_W-1:0] val_r;
  logic [VAL_W-1:0] nval_r;

  logic [VAL_W-1:0] cells [DEPTH];
  logic [VAL_W-1:0] cells_next [DEPTH];
  logic [CNT_W-1:0] count, count_next;

  status_t          status_r, status_next;
  logic [POS_W-1:0] found_r, found_next;
  logic [POS_W-1:0] len_r;

  logic [CMP_W-1:0] pos_ext, cnt_ext, pos_m1;
  logic             ins_bad, del_bad, full;
  logic             do_ins, do_del, do_amd;
  logic [DEPTH-1:0] eq, first;
  logic             any_match;
  logic [IDX_W-1:0] match_idx;

  assign pos_ext = CMP_W'(pos_r);
  assign cnt_ext = CMP_W'(count);
  assign pos_m1  = pos_ext - CMP_W'(1);

  assign ins_bad = (pos_r == '0) || (pos_ext > cnt_ext + CMP_W'(1));
  assign del_bad = (pos_r == '0) || (pos_ext > cnt_ext);
  assign full    = (count == CNT_W'(DEPTH));

  // compare every live cell, then isolate the lowest hit
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      eq[i] = (cells[i] == val_r) && (CMP_W'(i) < cnt_ext);
    end
  end

  assign first     = eq & (~eq + DEPTH'(1));
  assign any_match = |eq;

  always_comb begin
    logic [IDX_W-1:0] iv;
    match_idx = '0;
    for (int i = 0; i < DEPTH; i++) begin
      iv = IDX_W'(i);
      for (int b = 0; b < IDX_W; b++) begin
        if (first[i] && iv[b]) match_idx[b] = 1'b1;
      end
    end
  end

  always_comb begin
    do_ins      = 1'b0;
    do_del      = 1'b0;
    do_amd      = 1'b0;
    status_next = ST_OK;
    found_next  = '0;
    count_next  = count;
    case (cmd_t'(cmd_r))
      CMD_INSERT: begin
        if (ins_bad) status_next = ST_BAD_POS;
        else if (full) status_next = ST_FULL;
        else begin
          do_ins     = 1'b1;
          count_next = count + CNT_W'(1);
        end
      end
      CMD_DELETE: begin
        if (del_bad) status_next = ST_BAD_POS;
        else begin
          do_del     = 1'b1;
          count_next = count - CNT_W'(1);
        end
      end
      CMD_SEARCH, CMD_AMEND: begin
        if (any_match) begin
          found_next = POS_W'(CMP_W'(match_idx) + CMP_W'(1));
          do_amd     = (cmd_t'(cmd_r) == CMD_AMEND);
        end else begin
          status_next = ST_NOT_FOUND;
        end
      end
      default: status_next = ST_OK;
    endcase
  end

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [VAL_W-1:0] below, above;
    if (g == 0) begin : g_lo
      assign below = cells[g];
    end else begin : g_lo
      assign below = cells[g-1];
    end
    if (g == DEPTH - 1) begin : g_hi
      assign above = cells[g];
    end else begin : g_hi
      assign above = cells[g+1];
    end
    always_comb begin
      cells_next[g] = cells[g];
      if (do_ins) begin
        if (CMP_W'(g) > pos_m1) cells_next[g] = below;
        else if (CMP_W'(g) == pos_m1) cells_next[g] = val_r;
      end else if (do_del) begin
        if (CMP_W'(g) >= pos_m1) cells_next[g] = above;
      end else if (do_amd && first[g]) begin
        cells_next[g] = nval_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      cmd_r  <= in_data[CMD_W-1:0];
      pos_r  <= in_data[CMD_W +: POS_W];
      val_r  <= in_data[CMD_W+POS_W +: VAL_W];
      nval_r <= in_data[CMD_W+POS_W+VAL_W +: VAL_W];
    end
    if (ctrl.exec) begin
      for (int i = 0; i < DEPTH; i++) cells[i] <= cells_next[i];
      status_r <= status_next;
      found_r  <= found_next;
      len_r    <= POS_W'(count_next);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (ctrl.exec) begin
      count <= count_next;
    end
  end

  assign out_data = OUT_W'({len_r, found_r, status_r});

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH)) else $error("entry count above depth");
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    !ctrl.exec |=> count == $past(count)) else $error("count moved without exec");

endmodule

// ===== sv/ordered_list_insert_delete_search.sv =====
// Ordered list engine: insert, delete, search and amend over a cell chain.
// Flow: an accepted input transaction is captured into the command register, then
//   executed (all cells shift or compare at once) into the result register on m_tdata.
// A new command is taken only after the held one has executed, as the capture/execute
//   controller sets; a held result stalls execution only while m_tready stays low.
// Reset (rst, synchronous, active high) empties the list and drops any result.
module ordered_list_insert_delete_search (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  // s_tdata: cmd[1:0], position[6:2], value[38:7], new_value[70:39], zero pad
  input  logic [olist_pkg::IN_W-1:0]  s_tdata,
  output logic                        m_tvalid,
  input  logic                        m_tready,
  // m_tdata: status[1:0], found_position[6:2], list_length[11:7], zero pad
  output logic [olist_pkg::OUT_W-1:0] m_tdata
);
  import olist_pkg::*;

  dp_ctrl_t ctrl;

  // Controller: accept a transaction when idle, execute once the result
  // register is free, and hold the result valid until it is taken.
  olist_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .ctrl     (ctrl)
  );

  // Datapath: command register, the cell chain with its entry count, the
  // parallel comparators, and the result register.
  olist_dp u_dp (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (ctrl),
    .in_data  (s_tdata),
    .out_data (m_tdata)
  );

endmodule
